FILE: hdl/capture_period_to_rpm_macros.svh
// ---------------------------------------------------------------------------
// capture_period_to_rpm assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_TO_RPM_MACROS_SVH
`define CAPTURE_PERIOD_TO_RPM_MACROS_SVH

// implication checked every clock edge while out of reset
`define CPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cprpm_pkg.sv
// ---------------------------------------------------------------------------
// cprpm_pkg
// shared types and constants of the capture period to rpm tachometer
// ---------------------------------------------------------------------------
package cprpm_pkg;

  localparam int unsigned NUM_W     = 32;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned OVF_W     = 16;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned ADDR_W    = 2;

  localparam logic [NUM_W-1:0]  NUMERATOR_RESET = 32'd60000000;
  localparam logic [RPM_W-1:0]  RPM_MAX         = '1;
  localparam logic [OVF_W-1:0]  OVF_MAX         = '1;
  localparam logic [ADDR_W-1:0] ADDR_RATE_NUMERATOR = 2'd0;

  // event kinds carried in the input tuser
  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic overflow_inc;
    logic capture_load;
    logic div_step;
    logic out_load;
  } cprpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic period_zero;
  } cprpm_status_t;

endpackage

FILE: hdl/cprpm_datapath.sv
// ---------------------------------------------------------------------------
// cprpm_datapath
// period forming, event state, 32-step restoring divider, result register
// ---------------------------------------------------------------------------
module cprpm_datapath import cprpm_pkg::*; #(
  parameter int unsigned CAPTURE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cprpm_cmd_t        cmd_i,
  output cprpm_status_t     status_o,
  input  logic [CAP_W-1:0]  capture_value_i,
  input  logic              cfg_write_i,
  input  logic [NUM_W-1:0]  cfg_wdata_i,
  output logic [NUM_W-1:0]  rate_numerator_o,
  output logic [RPM_W-1:0]  rpm_o,
  output logic              saturated_o
);

  localparam logic [CAP_W-1:0] CapMask =
    (CAPTURE_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((64'd1 << CAPTURE_BITS) - 64'd1);

  logic [NUM_W-1:0] numerator_q;
  logic [OVF_W-1:0] ovf_q, ovf_d;
  logic [CAP_W-1:0] last_q, last_d;
  logic [NUM_W-1:0] divisor_q, divisor_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [RPM_W-1:0] rpm_q, rpm_d;
  logic             sat_q, sat_d;

  logic [CAP_W-1:0] cap;
  logic [NUM_W-1:0] diff;
  logic [63:0]      ovf_wide;
  logic [NUM_W-1:0] period;
  logic [NUM_W:0]   trial;

  // period = overflows shifted past the capture width plus the capture delta
  assign cap      = capture_value_i & CapMask;
  assign diff     = {{(NUM_W-CAP_W){1'b0}}, cap} - {{(NUM_W-CAP_W){1'b0}}, last_q};
  assign ovf_wide = 64'(ovf_q) << CAPTURE_BITS;
  assign period   = ovf_wide[NUM_W-1:0] + diff;

  assign status_o.period_zero = (period == '0);

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_q, quo_q[NUM_W-1]} - {1'b0, divisor_q};

  always_comb begin
    ovf_d     = ovf_q;
    last_d    = last_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    rpm_d     = rpm_q;
    sat_d     = sat_q;
    if (cmd_i.overflow_inc && ovf_q != OVF_MAX) begin
      ovf_d = ovf_q + OVF_W'(1);
    end
    if (cmd_i.capture_load) begin
      ovf_d     = '0;
      last_d    = cap;
      divisor_d = period;
      rem_d     = '0;
      quo_d     = numerator_q;
    end
    if (cmd_i.div_step) begin
      if (trial[NUM_W]) begin
        rem_d = {rem_q[NUM_W-2:0], quo_q[NUM_W-1]};
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end else begin
        rem_d = trial[NUM_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end
    end
    if (cmd_i.out_load) begin
      if (divisor_q == '0 || quo_q[NUM_W-1:RPM_W] != '0) begin
        rpm_d = RPM_MAX;
        sat_d = 1'b1;
      end else begin
        rpm_d = quo_q[RPM_W-1:0];
        sat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q <= NUMERATOR_RESET;
      ovf_q       <= '0;
      last_q      <= '0;
    end else begin
      if (cfg_write_i) begin
        numerator_q <= cfg_wdata_i;
      end
      ovf_q  <= ovf_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    rpm_q     <= rpm_d;
    sat_q     <= sat_d;
  end

  assign rate_numerator_o = numerator_q;
  assign rpm_o            = rpm_q;
  assign saturated_o      = sat_q;

endmodule

FILE: hdl/cprpm_ctrl.sv
// ---------------------------------------------------------------------------
// cprpm_ctrl
// sequencer for event intake, divider steps and result handoff
// ---------------------------------------------------------------------------
`include "capture_period_to_rpm_macros.svh"

module cprpm_ctrl import cprpm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_command_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  cprpm_status_t status_i,
  output cprpm_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_e;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(DIV_STEPS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              m_valid_q, m_valid_d;
  logic              accept;
  logic              out_free;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !m_valid_q || m_ready_i;

  always_comb begin
    state_d            = state_q;
    step_d             = step_q;
    cmd_o              = '0;
    cmd_o.overflow_inc = accept && (s_command_i == CMD_OVERFLOW);
    cmd_o.capture_load = accept && (s_command_i == CMD_CAPTURE);
    m_valid_d          = m_valid_q && !m_ready_i;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (cmd_o.capture_load) begin
          state_d = status_i.period_zero ? S_HOLD : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == LastStep) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

  `CPR_ASSERT_IMPL(a_load_into_free_slot, cmd_o.out_load, !m_valid_q || m_ready_i, "result overwritten")
  `CPR_ASSERT_NEXT(a_div_ends_in_hold, state_q == S_DIV && step_q == LastStep, state_q == S_HOLD, "divider overran")
  `CPR_ASSERT_NEXT(a_capture_starts_div, cmd_o.capture_load && !status_i.period_zero, state_q == S_DIV && step_q == '0, "capture did not start division")
  `CPR_ASSERT_NEXT(a_zero_period_skips, cmd_o.capture_load && status_i.period_zero, state_q == S_HOLD, "zero period not short-cut")

endmodule

FILE: hdl/capture_period_to_rpm.sv
// ---------------------------------------------------------------------------
// capture_period_to_rpm
// tachometer: timer capture period to revolutions per minute
// ---------------------------------------------------------------------------
// Events arrive on the input stream: tuser 0 is a timer overflow, which
// bumps a saturating 16-bit overflow count and produces no output transfer;
// tuser 1 is a capture edge whose timer value sits in tdata. A capture forms
// period = overflows * 2^CAPTURE_BITS + (capture - last capture), mod 2^32,
// clears the overflow count, keeps the capture as the new reference and
// divides rate_numerator (APB address 0, reset 60000000) by the period.
// The output transfer carries rpm in tdata and a saturated flag in tuser;
// the flag is set with rpm 65535 when the quotient does not fit 16 bits or
// the period is zero. An overflow event leaves the block ready for the next
// event. A capture holds the block: the cycle it is accepted in latches the
// period, 32 steps of the bit-serial restoring divider follow (one quotient
// bit per clock) and the hold state registers the result; a zero period
// skips the divider and goes from acceptance straight to the hold state.
// The next event is accepted as soon as the result is registered, while
// that result still waits on the output side; a capture that finishes
// while the previous result is still waiting holds until that result is
// taken.
// ---------------------------------------------------------------------------
module capture_period_to_rpm import cprpm_pkg::*; #(
  parameter int unsigned CAPTURE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // event input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] capture_value
  input  logic              s_axis_tuser,   // [0] command
  // result output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] rpm
  output logic              m_axis_tuser,   // [0] saturated
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cprpm_cmd_t       cmd;
  cprpm_status_t    status;
  logic             cfg_write;
  logic [NUM_W-1:0] rate_numerator;

  // register writes land on the access cycle, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_RATE_NUMERATOR);
  assign prdata    = (paddr == ADDR_RATE_NUMERATOR) ? rate_numerator : '0;

  // sequencer: intake, divider stepping, output slot handoff
  cprpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_command_i (s_axis_tuser),
    .s_ready_o   (s_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // period, event state, divider and result register
  cprpm_datapath #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .capture_value_i  (s_axis_tdata),
    .cfg_write_i      (cfg_write),
    .cfg_wdata_i      (pwdata),
    .rate_numerator_o (rate_numerator),
    .rpm_o            (m_axis_tdata),
    .saturated_o      (m_axis_tuser)
  );

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// capture_period_to_rpm testbench
// drives timer overflow and capture events into the tachometer, predicts
// each rpm result from its own copy of the overflow count, the last capture
// and the rate numerator, and checks every output transfer in order
// ---------------------------------------------------------------------------
module testbench import cprpm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPTURE_BITS     = 16;
  // pause before a register write and at the end, to let a capture finish
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PER_PHASE = 170;
  localparam int unsigned CYCLE_LIMIT      = 1000000;

  // one input transfer: event kind and captured timer value
  typedef struct packed {
    logic             cmd;
    logic [CAP_W-1:0] cap;
  } tach_event_t;

  // one output transfer: rpm and its saturation flag
  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             sat;
  } rpm_result_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;   // [15:0] capture_value
  logic              s_axis_tuser  = 1'b0; // [0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;         // [15:0] rpm
  logic              m_axis_tuser;         // [0] saturated
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // events waiting for the driver, rpm values waiting for the output side
  tach_event_t event_q[$];
  rpm_result_t rpm_expect_q[$];

  // predicted state of the tachometer
  logic [OVF_W-1:0] tach_ovf_cnt   = '0;
  logic [CAP_W-1:0] tach_last_cap  = '0;
  logic [NUM_W-1:0] tach_numerator = NUMERATOR_RESET;

  // last capture already queued, so that random periods can be planned
  logic [CAP_W-1:0] plan_last_cap = '0;

  // idling control, set between phases by the stimulus process
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_armed = 1'b0;
  logic hold_done  = 1'b0;

  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  capture_period_to_rpm #(
    .CAPTURE_BITS(CAPTURE_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the predicted state by one accepted event, queue the rpm it yields
  task automatic compute_rpm(input logic cmd, input logic [CAP_W-1:0] cap);
    logic [63:0]      span;
    logic [31:0]      diff;
    logic [31:0]      period;
    logic [31:0]      quot;
    logic [CAP_W-1:0] cap_used;
    rpm_result_t      res;
    if (cmd == CMD_OVERFLOW) begin
      // count saturates, it never wraps back to zero
      if (tach_ovf_cnt != OVF_MAX) tach_ovf_cnt = tach_ovf_cnt + 1'b1;
    end else begin
      // only the low CAPTURE_BITS bits of the capture take part
      if (CAPTURE_BITS >= CAP_W) cap_used = cap;
      else cap_used = cap & ((CAP_W'(1) << CAPTURE_BITS) - 1'b1);
      // overflow term drops out once it is shifted past 32 bits
      span = '0;
      if (CAPTURE_BITS < 32) span = 64'(tach_ovf_cnt) << CAPTURE_BITS;
      // a capture below the last one wraps modulo 2^32
      diff   = {16'b0, cap_used} - {16'b0, tach_last_cap};
      period = span[31:0] + diff;
      if (period == '0) begin
        res = '{rpm: RPM_MAX, sat: 1'b1};
      end else begin
        quot = tach_numerator / period;
        if (quot > 32'(RPM_MAX)) res = '{rpm: RPM_MAX, sat: 1'b1};
        else res = '{rpm: quot[RPM_W-1:0], sat: 1'b0};
      end
      tach_ovf_cnt  = '0;
      tach_last_cap = cap_used;
      rpm_expect_q.push_back(res);
    end
  endtask

  // event driver: offers queued events, optional gap after each transfer
  always @(posedge clk_i or negedge rst_ni) begin : event_driver
    tach_event_t ev;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) compute_rpm(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          ev = event_q.pop_front();
          s_axis_tuser  <= ev.cmd;
          s_axis_tdata  <= ev.cap;
          s_axis_tvalid <= 1'b1;
          tx_gap        <= tx_idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each output transfer with the oldest prediction
  // and stalls tready for a drawn number of cycles afterwards
  always @(posedge clk_i or negedge rst_ni) begin : rpm_monitor
    rpm_result_t exp_res;
    int unsigned pause;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (rpm_expect_q.size() == 0) begin
        $display("%0t: unexpected rpm transfer, rpm %0d saturated %0b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        exp_res = rpm_expect_q.pop_front();
        if (m_axis_tdata !== exp_res.rpm) begin
          $display("%0t: rpm mismatch, expected %0d, actual %0d",
                   $time, exp_res.rpm, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== exp_res.sat) begin
          $display("%0t: saturated mismatch, expected %0b, actual %0b",
                   $time, exp_res.sat, m_axis_tuser);
          mismatch_cnt++;
        end
      end
      // one long hold while the sender keeps going, so the input backs up
      if (hold_armed && !hold_done) begin
        hold_done     <= 1'b1;
        rx_wait       <= LONG_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        pause         = rx_idle_on ? $urandom_range(0, 7) : 0;
        rx_wait       <= pause;
        m_axis_tready <= (pause == 0);
      end
    end else if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_event(input logic cmd, input logic [CAP_W-1:0] cap);
    event_q.push_back('{cmd: cmd, cap: cap});
    if (cmd == CMD_CAPTURE) plan_last_cap = cap;
  endfunction

  // wait until every queued event is taken and every rpm has come back;
  // sampled on the falling edge so all updates of the rising edge are seen
  task automatic wait_drained();
    do @(negedge clk_i);
    while (event_q.size() != 0 || s_axis_tvalid || rpm_expect_q.size() != 0);
  endtask

  // write rate_numerator once the block has gone quiet
  task automatic write_numerator(input logic [NUM_W-1:0] value);
    wait_drained();
    // a trailing overflow gives no transfer to wait for
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_RATE_NUMERATOR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tach_numerator = value;
  endtask

  // mostly overflow bursts closed by a capture, the rest loose events
  task automatic queue_random_events(input int unsigned count);
    int unsigned      made;
    int unsigned      n_ovf;
    logic [CAP_W-1:0] cap;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        n_ovf = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 24) : $urandom_range(0, 2);
        repeat (n_ovf) push_event(CMD_OVERFLOW, CAP_W'($urandom));
        case ($urandom_range(0, 3))
          0: cap = plan_last_cap;                                   // zero or whole-wrap span
          1: cap = plan_last_cap + CAP_W'($urandom_range(1, 2000)); // short period
          default: cap = CAP_W'($urandom);
        endcase
        push_event(CMD_CAPTURE, cap);
        made += n_ovf + 1;
      end else begin
        push_event($urandom_range(0, 1) ? CMD_CAPTURE : CMD_OVERFLOW, CAP_W'($urandom));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset numerator
    push_event(CMD_CAPTURE, 16'h0000);      // zero period right after reset
    push_event(CMD_OVERFLOW, 16'hFFFF);
    push_event(CMD_CAPTURE, 16'h0000);      // exactly one timer wrap
    push_event(CMD_CAPTURE, 16'd1000);      // 60000 rpm
    push_event(CMD_CAPTURE, 16'd1900);      // quotient above 16 bits
    push_event(CMD_CAPTURE, 16'hFFFF);
    push_event(CMD_CAPTURE, 16'h0005);      // timer wrapped but no overflow seen
    push_event(CMD_OVERFLOW, 16'h0000);
    push_event(CMD_CAPTURE, 16'h000A);      // overflow supplies the missing span
    repeat (3) push_event(CMD_OVERFLOW, 16'h5555);
    push_event(CMD_CAPTURE, 16'h5555);
    push_event(CMD_CAPTURE, 16'hAAAA);
    push_event(CMD_CAPTURE, 16'hAAAA);      // zero period again
    repeat (2) push_event(CMD_OVERFLOW, 16'hAAAA);
    push_event(CMD_CAPTURE, 16'hAAAA);      // only overflow term left

    // largest numerator, a wrap-around period and a long overflow burst
    write_numerator('1);
    push_event(CMD_CAPTURE, plan_last_cap + 1'b1);
    push_event(CMD_CAPTURE, plan_last_cap - 1'b1);  // period of 2^32 - 2
    wait_drained();
    tx_idle_on = 1'b0;
    repeat (40) push_event(CMD_OVERFLOW, CAP_W'($urandom));
    push_event(CMD_CAPTURE, plan_last_cap);
    push_event(CMD_CAPTURE, plan_last_cap + 1'b1);

    // zero numerator
    write_numerator('0);
    tx_idle_on = 1'b1;
    push_event(CMD_CAPTURE, plan_last_cap + 16'h0010);
    push_event(CMD_CAPTURE, plan_last_cap);
    push_event(CMD_OVERFLOW, 16'h1234);
    push_event(CMD_CAPTURE, plan_last_cap + 16'h1234);

    // smallest numerators and the 16-bit boundary of the quotient
    write_numerator(32'd1);
    push_event(CMD_CAPTURE, plan_last_cap + 1'b1);
    push_event(CMD_CAPTURE, plan_last_cap + 2'd2);
    write_numerator(32'h0000_FFFF);
    push_event(CMD_CAPTURE, plan_last_cap + 1'b1);
    write_numerator(32'h0001_0000);
    push_event(CMD_CAPTURE, plan_last_cap + 1'b1);

    // random phases, each under its own numerator and idling pattern
    write_numerator(NUMERATOR_RESET);
    queue_random_events(RANDOM_PER_PHASE);

    write_numerator($urandom);
    hold_armed = 1'b1;
    queue_random_events(RANDOM_PER_PHASE);

    write_numerator($urandom_range(1, 2000000));
    tx_idle_on = 1'b0;
    queue_random_events(RANDOM_PER_PHASE);

    write_numerator(32'hFFFF_FFFF - $urandom_range(0, 1000));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    queue_random_events(RANDOM_PER_PHASE);

    write_numerator($urandom);
    tx_idle_on = 1'b0;
    queue_random_events(RANDOM_PER_PHASE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && rpm_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cprpm_pkg.sv
hdl/cprpm_datapath.sv
hdl/cprpm_ctrl.sv
hdl/capture_period_to_rpm.sv
sim/testbench.sv
